FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Item layouts, status codes and cell interface types.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned LEVELS       = 3;
  localparam int unsigned LEVEL_W      = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_BAD_LEVEL = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0]        level;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic [LEVEL_W-1:0]        out_level;
  } out_item_t;

  typedef struct packed {
    logic                      vld;
    logic [LEVEL_W-1:0]        level;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic [LEVEL_W-1:0]        level;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  localparam entry_t EMPTY_ENTRY = '{vld: 1'b0, level: '0, value: '0};

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the priority queue chain
// Holds one entry; on insert keeps, loads the new entry or takes its
// predecessor; on delete takes its successor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    prev_entry,
  input  logic               prev_keep,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry,
  output logic               keep
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign keep  = entry_r.vld && (entry_r.level <= ctrl.level);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (prev_keep) begin
        entry_nxt = '{vld: 1'b1, level: ctrl.level, value: ctrl.value};
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctrl.del) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else begin
      entry_r.vld <= entry_nxt.vld;
    end
    entry_r.level <= entry_nxt.level;
    entry_r.value <= entry_nxt.value;
  end

endmodule

FILE: rtl/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core: bounded stable priority queue
// A row of CAPACITY cells holds entries sorted by level, front at cell 0.
//
// Usage:
//   in_data carries op, value and level; an item is taken when in_valid and
//   in_ready are both high. Each item gives exactly one result on out_data.
//   Insert places the value behind all entries of equal or better level;
//   delete returns the front entry. Bad level, underflow and overflow are
//   reported in status with zero value and level.
//   out_valid rises in the cycle after acceptance; one item per cycle is
//   sustained while out_ready is high, as all cells compare and shift at once.
//   The result sits in an output register; in_ready stays high while that
//   register is empty or being drained, so a stalled receiver holds the
//   result and blocks only further input.
//   Reset clears every cell's valid bit, leaving the queue empty, and clears
//   out_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  entry_t     ent  [CAPACITY];
  logic       keep [CAPACITY];
  cell_ctrl_t ctrl;
  logic       accept;
  logic       bad_level;
  logic       empty;
  logic       full;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign bad_level = (in_data.level == '0) || (in_data.level > LEVEL_W'(LEVELS));
  assign empty     = !ent[0].vld;
  assign full      = ent[CAPACITY-1].vld;

  always_comb begin
    ctrl.ins   = accept && (in_data.op == OP_INSERT) && !bad_level && !full;
    ctrl.del   = accept && (in_data.op == OP_DELETE) && !empty;
    ctrl.level = in_data.level;
    ctrl.value = in_data.value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;
    if (i == 0) begin : g_head
      assign prev_e = EMPTY_ENTRY;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_k = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = EMPTY_ENTRY;
    end else begin : g_mid
      assign next_e = ent[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .entry      (ent[i]),
      .keep       (keep[i])
    );
  end

  always_comb begin
    out_data_nxt = '{status: ST_INSERTED, out_value: '0, out_level: '0};
    priority if (in_data.op == OP_DELETE) begin
      if (empty) begin
        out_data_nxt.status = ST_UNDERFLOW;
      end else begin
        out_data_nxt.status    = ST_DELETED;
        out_data_nxt.out_value = ent[0].value;
        out_data_nxt.out_level = ent[0].level;
      end
    end else if (bad_level) begin
      out_data_nxt.status = ST_BAD_LEVEL;
    end else if (full) begin
      out_data_nxt.status = ST_OVERFLOW;
    end else begin
      out_data_nxt.status = ST_INSERTED;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item gave no result");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DELETED) |->
      (out_data.out_value == '0 && out_data.out_level == '0))
    else $error("non-delete result carries data");

  a_deleted_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DELETED) |->
      (out_data.out_level != '0 && out_data.out_level <= LEVEL_W'(LEVELS)))
    else $error("deleted entry has invalid level");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
